@@ hdl/sobel_edge_threshold_assert.svh @@
// Assertion macros shared by the edge detector RTL.
`ifndef SOBEL_EDGE_THRESHOLD_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SOBEL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SOBEL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sobel_pkg.sv @@
// Shared types, constants and helper functions of the edge detector.
package sobel_pkg;

  localparam int MAX_LINE_WIDTH = 2048;
  localparam int STORE_DEPTH    = 2 * MAX_LINE_WIDTH + 3;
  localparam int PTR_W          = $clog2(STORE_DEPTH);
  localparam int LW_W           = 12;
  localparam int WEFF_W         = $clog2(MAX_LINE_WIDTH + 1);

  typedef logic [7:0]               luma_t;
  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [LW_W-1:0]          lw_t;
  typedef logic [WEFF_W-1:0]        weff_t;
  typedef logic signed [3:0]        coef_t;
  typedef logic signed [12:0]       prod_t;
  typedef logic signed [14:0]       row_t;
  typedef logic signed [16:0]       sum_t;
  typedef logic [17:0]              mag_t;

  localparam luma_t       BLACK_LUMA       = 8'd16;
  localparam logic [23:0] EDGE_WHITE       = 24'hFFFFFF;
  localparam logic [15:0] THRESHOLD_RESET  = 16'd128;
  localparam lw_t         LINE_WIDTH_RESET = 12'd800;
  localparam logic [35:0] X_KERNEL_RESET   = 36'h121000FEF;
  localparam logic [35:0] Y_KERNEL_RESET   = 36'h10F20E10F;

  typedef enum logic [7:0] {
    REG_THRESHOLD  = 8'd0,
    REG_LINE_WIDTH = 8'd1,
    REG_X_KERNEL   = 8'd2,
    REG_Y_KERNEL   = 8'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RF_IDLE,
    RF_FAR,
    RF_NEAR,
    RF_LOAD
  } refill_e;

  typedef struct packed {
    logic  write;
    logic  last;
    luma_t luma;
    logic  lw_change;
  } store_ctl_t;

  typedef struct packed {
    logic busy;
    logic shift;
  } store_stat_t;

  function automatic luma_t rgb_to_luma(input logic [23:0] rgb);
    logic [15:0] acc;
    acc = 16'(rgb[23:16]) * 16'd66 + 16'(rgb[15:8]) * 16'd129
        + 16'(rgb[7:0]) * 16'd25 + 16'd128;
    return acc[15:8] + BLACK_LUMA;
  endfunction

  // Clamp the programmed width into 3..MAX_LINE_WIDTH.
  function automatic weff_t eff_width(input lw_t lw);
    weff_t w;
    if (lw < lw_t'(3)) begin
      w = weff_t'(3);
    end else if (32'(lw) > MAX_LINE_WIDTH) begin
      w = weff_t'(MAX_LINE_WIDTH);
    end else begin
      w = weff_t'(lw);
    end
    return w;
  endfunction

  // base - dly modulo the store depth; dly never exceeds the depth.
  function automatic ptr_t wrap_sub(input ptr_t base, input ptr_t dly);
    logic [PTR_W:0] wide;
    if (base >= dly) begin
      wide = {1'b0, base} - {1'b0, dly};
    end else begin
      wide = {1'b0, base} + STORE_DEPTH[PTR_W:0] - {1'b0, dly};
    end
    return wide[PTR_W-1:0];
  endfunction

endpackage

@@ hdl/sobel_cell.sv @@
// One window tap: holds a luma, hands it on, forms both kernel products.
module sobel_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  sobel_pkg::luma_t    luma_i,
  input  sobel_pkg::coef_t    x_coef_i,
  input  sobel_pkg::coef_t    y_coef_i,
  output sobel_pkg::luma_t    luma_o,
  output sobel_pkg::prod_t    x_prod_o,
  output sobel_pkg::prod_t    y_prod_o
);

  sobel_pkg::luma_t luma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_q <= sobel_pkg::BLACK_LUMA;
    end else if (shift_i) begin
      luma_q <= luma_i;
    end
  end

  assign luma_o   = luma_q;
  assign x_prod_o = sobel_pkg::prod_t'($signed({1'b0, luma_q}))
                  * sobel_pkg::prod_t'(x_coef_i);
  assign y_prod_o = sobel_pkg::prod_t'($signed({1'b0, luma_q}))
                  * sobel_pkg::prod_t'(y_coef_i);

endmodule

@@ hdl/sobel_store.sv @@
// Circular luma line store with fill count and tap refill sequencer.
module sobel_store (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sobel_pkg::store_ctl_t  ctl_i,
  input  sobel_pkg::weff_t       width_i,
  output sobel_pkg::luma_t       row1_luma_o,
  output sobel_pkg::luma_t       row2_luma_o,
  output sobel_pkg::store_stat_t stat_o
);

  sobel_pkg::luma_t   mem [sobel_pkg::STORE_DEPTH];
  sobel_pkg::ptr_t    ptr_q, ptr_next;
  sobel_pkg::ptr_t    fill_q, fill_inc, fill_eff;
  sobel_pkg::ptr_t    base, dly1, dly2, addr1, addr2, w_ext;
  sobel_pkg::refill_e state_q, state_d;
  sobel_pkg::luma_t   rd1_q, rd2_q;
  logic               val1_q, val2_q;
  logic               rd_en, shift;

  assign w_ext    = sobel_pkg::ptr_t'(width_i);
  assign ptr_next = (ptr_q == sobel_pkg::ptr_t'(sobel_pkg::STORE_DEPTH - 1))
                  ? '0 : ptr_q + 1'b1;
  // saturates once every tap lies inside the current frame
  assign fill_inc = (fill_q == sobel_pkg::ptr_t'(sobel_pkg::STORE_DEPTH))
                  ? fill_q : fill_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    base     = ptr_next;
    fill_eff = fill_inc;
    dly1     = w_ext;
    dly2     = w_ext << 1;
    rd_en    = ctl_i.write;
    shift    = 1'b0;
    unique case (state_q)
      sobel_pkg::RF_IDLE: begin
      end
      sobel_pkg::RF_FAR: begin
        // taps one pixel older than the row heads
        base     = ptr_q;
        fill_eff = fill_q;
        dly1     = w_ext + 1'b1;
        dly2     = (w_ext << 1) + 1'b1;
        rd_en    = 1'b1;
        state_d  = sobel_pkg::RF_NEAR;
      end
      sobel_pkg::RF_NEAR: begin
        base     = ptr_q;
        fill_eff = fill_q;
        rd_en    = 1'b1;
        shift    = 1'b1;
        state_d  = sobel_pkg::RF_LOAD;
      end
      sobel_pkg::RF_LOAD: begin
        shift    = 1'b1;
        state_d  = sobel_pkg::RF_IDLE;
      end
    endcase
    if (ctl_i.lw_change) begin
      state_d = sobel_pkg::RF_FAR;
    end
  end

  assign addr1 = sobel_pkg::wrap_sub(base, dly1);
  assign addr2 = sobel_pkg::wrap_sub(base, dly2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sobel_pkg::RF_IDLE;
      ptr_q   <= '0;
      fill_q  <= '0;
      val1_q  <= 1'b0;
      val2_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_i.write) begin
        ptr_q  <= ptr_next;
        fill_q <= ctl_i.last ? '0 : fill_inc;
      end
      if (rd_en) begin
        val1_q <= dly1 < fill_eff;
        val2_q <= dly2 < fill_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.write) begin
      mem[ptr_next] <= ctl_i.luma;
    end
    if (rd_en) begin
      rd1_q <= mem[addr1];
      rd2_q <= mem[addr2];
    end
  end

  // entries older than the frame read as black
  assign row1_luma_o  = val1_q ? rd1_q : sobel_pkg::BLACK_LUMA;
  assign row2_luma_o  = val2_q ? rd2_q : sobel_pkg::BLACK_LUMA;
  assign stat_o.busy  = state_q != sobel_pkg::RF_IDLE;
  assign stat_o.shift = shift;

endmodule

@@ hdl/sobel_edge_threshold.sv @@
// Top level of the 3x3 edge detector with threshold.
//
// Takes one RGB pixel per word in raster order and returns one word per
// pixel: all ones where |x| + |y| of the two programmable 3x3 kernel
// responses exceeds the threshold, zero otherwise. Throughput is one pixel
// per clock while the output is ready and no refill or register write holds
// the pipe. The window is a 3x3 grid of tap cells: row 0 is fed straight from
// the luma stage, rows 1 and 2 from a two-read-port line store of 2*2048+3
// lumas whose row heads sit at one and two line widths of delay. Windows wrap
// across line ends. A fill count marks how much of the store belongs to the
// current frame, so entries beyond it read as black (luma 16) after reset and
// after the last pixel of each frame, with no clearing pass. Writing
// line_width reloads the delayed tap cells in the far, near and load refill
// states, while pixels wait in the luma stage. The config port is ready only
// while the whole pipeline is empty, and a pending register write holds off
// new pixels until it lands; register writes belong between frames.
`include "sobel_edge_threshold_assert.svh"

module sobel_edge_threshold (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [23:0] pixel_rgb
  input  logic        s_axis_tlast_i,   // last_of_frame
  // edge output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [23:0] edge_pixel
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [35:0] cfg_data_i
);

  // config registers
  logic [15:0]      threshold_q;
  sobel_pkg::lw_t   line_width_q;
  logic [35:0]      x_kernel_q, y_kernel_q;

  // pipeline: L luma, R store read, C tap cells, S row sums, M magnitude, O out
  logic vl_q, vr_q, vc_q, vs_q, vm_q, vo_q;
  logic rdy_l, rdy_r, rdy_c, rdy_s, rdy_m, rdy_o;
  logic mv_l, mv_r, mv_c, mv_s, mv_m, mv_o;
  logic hold, cfg_fire, lw_wr, flush_q;

  sobel_pkg::luma_t luma_l_q, luma_r_q;
  logic             last_l_q, last_r_q;

  sobel_pkg::store_ctl_t  store_ctl;
  sobel_pkg::store_stat_t stat;
  sobel_pkg::luma_t       row_head [3];

  sobel_pkg::luma_t cell_luma [3][3];
  sobel_pkg::prod_t x_prod [3][3];
  sobel_pkg::prod_t y_prod [3][3];

  sobel_pkg::row_t x_row_q [3];
  sobel_pkg::row_t y_row_q [3];
  sobel_pkg::sum_t x_sum, y_sum;
  sobel_pkg::mag_t x_abs, y_abs, mag_q;
  logic            edge_q;

  // ---- config port ----
  // writes land only with no pixel in flight
  assign cfg_ready_o = !(vl_q || vr_q || vc_q || vs_q || vm_q || vo_q);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign lw_wr       = cfg_fire && (cfg_index_i == sobel_pkg::REG_LINE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= sobel_pkg::THRESHOLD_RESET;
      line_width_q <= sobel_pkg::LINE_WIDTH_RESET;
      x_kernel_q   <= sobel_pkg::X_KERNEL_RESET;
      y_kernel_q   <= sobel_pkg::Y_KERNEL_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        sobel_pkg::REG_THRESHOLD:  threshold_q  <= cfg_data_i[15:0];
        sobel_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data_i[sobel_pkg::LW_W-1:0];
        sobel_pkg::REG_X_KERNEL:   x_kernel_q   <= cfg_data_i;
        sobel_pkg::REG_Y_KERNEL:   y_kernel_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---- stage handshakes ----
  // the store must not advance while the tap cells are being reloaded
  assign hold  = stat.busy || lw_wr;
  assign rdy_o = !vo_q || m_axis_tready_i;
  assign rdy_m = !vm_q || rdy_o;
  assign rdy_s = !vs_q || rdy_m;
  assign rdy_c = !vc_q || rdy_s;
  assign rdy_r = !vr_q || rdy_c;
  assign rdy_l = !vl_q || (rdy_r && !hold);

  // a pending register write keeps new pixels out so the pipe can drain
  assign s_axis_tready_o = rdy_l && !cfg_valid_i;

  assign mv_l = s_axis_tvalid_i && s_axis_tready_o;
  assign mv_r = vl_q && rdy_r && !hold;
  assign mv_c = vr_q && rdy_c;
  assign mv_s = vc_q && rdy_s;
  assign mv_m = vs_q && rdy_m;
  assign mv_o = vm_q && rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q    <= 1'b0;
      vr_q    <= 1'b0;
      vc_q    <= 1'b0;
      vs_q    <= 1'b0;
      vm_q    <= 1'b0;
      vo_q    <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      if (rdy_l) vl_q <= mv_l;
      if (rdy_r) vr_q <= vl_q && !hold;
      if (rdy_c) vc_q <= vr_q;
      if (rdy_s) vs_q <= vc_q;
      if (rdy_m) vm_q <= vs_q;
      if (rdy_o) vo_q <= vm_q;
      // after a frame's last pixel the next window starts from black
      if (mv_c) flush_q <= last_r_q;
    end
  end

  // ---- luma and store stages ----
  always_ff @(posedge clk_i) begin
    if (mv_l) begin
      luma_l_q <= sobel_pkg::rgb_to_luma(s_axis_tdata_i);
      last_l_q <= s_axis_tlast_i;
    end
    if (mv_r) begin
      luma_r_q <= luma_l_q;
      last_r_q <= last_l_q;
    end
  end

  assign store_ctl.write     = mv_r;
  assign store_ctl.last      = last_l_q;
  assign store_ctl.luma      = luma_l_q;
  assign store_ctl.lw_change = lw_wr;

  sobel_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (store_ctl),
    .width_i     (sobel_pkg::eff_width(line_width_q)),
    .row1_luma_o (row_head[1]),
    .row2_luma_o (row_head[2]),
    .stat_o      (stat)
  );

  assign row_head[0] = luma_r_q;

  // ---- 3x3 tap cells, tap k = 3*row + col ----
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      sobel_pkg::luma_t din;
      logic             shift;

      if (gj == 0) begin : g_head
        assign din = row_head[gi];
      end else begin : g_tail
        assign din = flush_q ? sobel_pkg::BLACK_LUMA : cell_luma[gi][gj-1];
      end

      if (gi == 0) begin : g_live
        assign shift = mv_c;
      end else begin : g_delayed
        assign shift = mv_c || stat.shift;
      end

      sobel_cell u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (shift),
        .luma_i   (din),
        .x_coef_i (x_kernel_q[4*(3*gi+gj) +: 4]),
        .y_coef_i (y_kernel_q[4*(3*gi+gj) +: 4]),
        .luma_o   (cell_luma[gi][gj]),
        .x_prod_o (x_prod[gi][gj]),
        .y_prod_o (y_prod[gi][gj])
      );
    end
  end

  // ---- row sums, magnitude, threshold ----
  always_ff @(posedge clk_i) begin
    if (mv_s) begin
      for (int r = 0; r < 3; r++) begin
        x_row_q[r] <= sobel_pkg::row_t'(x_prod[r][0]) + sobel_pkg::row_t'(x_prod[r][1])
                    + sobel_pkg::row_t'(x_prod[r][2]);
        y_row_q[r] <= sobel_pkg::row_t'(y_prod[r][0]) + sobel_pkg::row_t'(y_prod[r][1])
                    + sobel_pkg::row_t'(y_prod[r][2]);
      end
    end
    if (mv_m) begin
      mag_q <= x_abs + y_abs;
    end
    if (mv_o) begin
      edge_q <= mag_q > sobel_pkg::mag_t'(threshold_q);
    end
  end

  always_comb begin
    x_sum = sobel_pkg::sum_t'(x_row_q[0]) + sobel_pkg::sum_t'(x_row_q[1])
          + sobel_pkg::sum_t'(x_row_q[2]);
    y_sum = sobel_pkg::sum_t'(y_row_q[0]) + sobel_pkg::sum_t'(y_row_q[1])
          + sobel_pkg::sum_t'(y_row_q[2]);
    x_abs = (x_sum < 0) ? sobel_pkg::mag_t'(-x_sum) : sobel_pkg::mag_t'(x_sum);
    y_abs = (y_sum < 0) ? sobel_pkg::mag_t'(-y_sum) : sobel_pkg::mag_t'(y_sum);
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = edge_q ? sobel_pkg::EDGE_WHITE : '0;

  // ---- checks ----
  `SOBEL_ASSERT_NOW(a_refill_empty, stat.busy, !(vr_q || vc_q),
    "tap refill overlaps a pixel in the read or tap stage")
  `SOBEL_ASSERT_NEXT(a_refill_start, lw_wr, stat.busy,
    "line width write did not start a tap refill")
  `SOBEL_ASSERT_NEXT(a_frame_flush, mv_c && last_r_q, flush_q,
    "frame end did not arm the window flush")

endmodule
